FILE: rtl/scan_edge_object_segmenter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan edge object segmenter
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCAN_EDGE_OBJECT_SEGMENTER_UNIT_DEFINES_SVH
`define SCAN_EDGE_OBJECT_SEGMENTER_UNIT_DEFINES_SVH

// General property check on the module clock and reset.
`define SEOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen.
`define SEOS_ASSERT_NEVER(lbl, expr, msg) \
  `SEOS_ASSERT(lbl, !(expr), msg)

`endif

FILE: rtl/seos_pkg.sv
// ----------------------------------------------------------------------------
// Scan edge object segmenter package
// Types and codes shared by the front end and the back end; the top level takes the queue depth from here.
// ----------------------------------------------------------------------------
package seos_pkg;

  localparam int unsigned THR_W      = 12;
  localparam int unsigned MINW_W     = 8;
  localparam int unsigned MAXO_W     = 4;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [THR_W-1:0]  THR_RESET  = 12'd130;
  localparam logic [MINW_W-1:0] MINW_RESET = 8'd4;
  localparam logic [MAXO_W-1:0] MAXO_RESET = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_THRESHOLD = 2'd0,
    CFG_MIN_WIDTH      = 2'd1,
    CFG_MAX_OBJECTS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_OBJECT  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Which results one accepted point causes.
  typedef struct packed {
    logic has_obj;
    logic has_sum;
  } cmd_t;

  // Object record part of a queue entry.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [ANGLE_W-1:0] center;
    logic [ANGLE_W-1:0] end_ang;
    logic [ANGLE_W-1:0] start_ang;
    logic [COUNT_W-1:0] id;
  } obj_t;

endpackage

FILE: rtl/seos_front.sv
// ----------------------------------------------------------------------------
// Segmenter front end
// Holds the sweep state and the registers, classifies each accepted point
// and produces one queue entry describing its results if it causes any.
// ----------------------------------------------------------------------------
module seos_front #(
  parameter int unsigned IR_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [seos_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [seos_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             valid_i,
  input  logic [seos_pkg::ANGLE_W-1:0]     angle_i,
  input  logic [IR_BITS-1:0]               ir_i,
  input  logic                             first_i,
  input  logic                             last_i,
  output logic                             push_o,
  output seos_pkg::cmd_t                   cmd_o,
  output seos_pkg::obj_t                   obj_o,
  output logic [IR_BITS-1:0]               delta_o,
  output logic [IR_BITS-1:0]               lo_o,
  output logic [IR_BITS-1:0]               hi_o
);

  localparam int unsigned CW = (IR_BITS > seos_pkg::THR_W) ? IR_BITS : seos_pkg::THR_W;

  logic [seos_pkg::THR_W-1:0]   thr_q;
  logic [seos_pkg::MINW_W-1:0]  minw_q;
  logic [seos_pkg::MAXO_W-1:0]  maxo_q;

  logic [IR_BITS-1:0]           prev_rd_q, prev_rd_d;
  logic                         inside_q, inside_d;
  logic [seos_pkg::ANGLE_W-1:0] start_q, start_d;
  logic [seos_pkg::ANGLE_W-1:0] prev_ang_q, prev_ang_d;
  logic [seos_pkg::COUNT_W-1:0] total_q, total_d;
  logic [IR_BITS-1:0]           ldelta_q, ldelta_d;
  logic [IR_BITS-1:0]           lo_q, lo_d;
  logic [IR_BITS-1:0]           hi_q, hi_d;

  logic                         ge, over, rise, fall, obj_hit;
  logic [IR_BITS-1:0]           mag;
  logic [seos_pkg::ANGLE_W-1:0] width;
  logic [seos_pkg::ANGLE_W:0]   ang_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= seos_pkg::THR_RESET;
      minw_q <= seos_pkg::MINW_RESET;
      maxo_q <= seos_pkg::MAXO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        seos_pkg::CFG_EDGE_THRESHOLD: thr_q  <= cfg_data_i[seos_pkg::THR_W-1:0];
        seos_pkg::CFG_MIN_WIDTH:      minw_q <= cfg_data_i[seos_pkg::MINW_W-1:0];
        seos_pkg::CFG_MAX_OBJECTS:    maxo_q <= cfg_data_i[seos_pkg::MAXO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ge    = (ir_i >= prev_rd_q);
    mag   = ge ? (ir_i - prev_rd_q) : (prev_rd_q - ir_i);
    over  = (CW'(mag) > CW'(thr_q));
    rise  = (ir_i > prev_rd_q) && over;
    fall  = (prev_rd_q > ir_i) && over;
    width = angle_i - start_q;

    inside_d   = inside_q;
    start_d    = start_q;
    total_d    = total_q;
    ldelta_d   = ldelta_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    prev_rd_d  = ir_i;
    prev_ang_d = angle_i;
    obj_hit    = 1'b0;

    if (first_i) begin
      inside_d = 1'b0;
      start_d  = '0;
      total_d  = '0;
      ldelta_d = '0;
      lo_d     = ir_i;
      hi_d     = ir_i;
    end else begin
      if (mag > ldelta_q) ldelta_d = mag;
      if (ir_i < lo_q)    lo_d = ir_i;
      if (ir_i > hi_q)    hi_d = ir_i;
      if (!inside_q && rise) begin
        inside_d = 1'b1;
        start_d  = prev_ang_q;
      end else if (inside_q && (fall || last_i)) begin
        inside_d = 1'b0;
        // A backwards angle gives a negative width, which is never reported.
        if ((angle_i >= start_q) && (width >= minw_q) && (total_q < maxo_q)) begin
          total_d = total_q + 1'b1;
          obj_hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rd_q  <= '0;
      inside_q   <= 1'b0;
      start_q    <= '0;
      prev_ang_q <= '0;
      total_q    <= '0;
      ldelta_q   <= '0;
      lo_q       <= '1;
      hi_q       <= '0;
    end else if (valid_i) begin
      prev_rd_q  <= prev_rd_d;
      inside_q   <= inside_d;
      start_q    <= start_d;
      prev_ang_q <= prev_ang_d;
      total_q    <= total_d;
      ldelta_q   <= ldelta_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
    end
  end

  assign ang_sum       = {1'b0, start_q} + {1'b0, angle_i};
  assign push_o        = valid_i && (obj_hit || last_i);
  assign cmd_o.has_obj = obj_hit;
  assign cmd_o.has_sum = last_i;
  assign obj_o.id        = total_d;
  assign obj_o.start_ang = start_q;
  assign obj_o.end_ang   = angle_i;
  assign obj_o.center    = ang_sum[seos_pkg::ANGLE_W:1];
  assign obj_o.count     = total_d;
  assign delta_o = ldelta_d;
  assign lo_o    = lo_d;
  assign hi_o    = hi_d;

endmodule

FILE: rtl/seos_queue.sv
// ----------------------------------------------------------------------------
// Segmenter entry queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module seos_queue #(
  parameter int unsigned WIDTH = 70,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]  LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNW-1:0] FULL_CNT = CNW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: rtl/seos_back.sv
// ----------------------------------------------------------------------------
// Segmenter back end
// Expands each queue entry into its object record, its sweep summary or both, and
// drives the result stream from an output register.
// ----------------------------------------------------------------------------
`include "scan_edge_object_segmenter_unit_defines.svh"

module seos_back #(
  parameter int unsigned IR_BITS = 12,
  parameter int unsigned OUT_W   = 72
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  seos_pkg::cmd_t       cmd_i,
  input  seos_pkg::obj_t       obj_i,
  input  logic [IR_BITS-1:0]   delta_i,
  input  logic [IR_BITS-1:0]   lo_i,
  input  logic [IR_BITS-1:0]   hi_i,
  output logic                 pop_o,
  output logic                 tvalid_o,
  input  logic                 tready_i,
  output logic [OUT_W-1:0]     tdata_o,
  output logic                 tuser_o,
  output logic                 tlast_o
);

  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q, out_data_d;
  seos_pkg::kind_e       out_kind_q, out_kind_d;
  logic                  out_last_q, out_last_d;
  logic                  phase_q, phase_d;
  logic                  load;
  seos_pkg::obj_t        obj_rec;

  // The output register takes a new result when one is queued and the register is empty or being drained.
  assign load = !empty_i && (!out_valid_q || tready_i);

  always_comb begin
    obj_rec    = obj_i;
    out_data_d = out_data_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    phase_d    = phase_q;
    pop_o      = 1'b0;
    if (load) begin
      priority if (cmd_i.has_obj && !phase_q) begin
        out_data_d = OUT_W'({obj_rec.count, {(3 * IR_BITS){1'b0}}, obj_rec.center,
                             obj_rec.end_ang, obj_rec.start_ang, obj_rec.id});
        out_kind_d = seos_pkg::KIND_OBJECT;
        out_last_d = !cmd_i.has_sum;
        // When the entry also has a summary, a second result follows from the same entry.
        phase_d    = cmd_i.has_sum;
        pop_o      = !cmd_i.has_sum;
      end else begin
        out_data_d = OUT_W'({obj_rec.count, hi_i, lo_i, delta_i,
                             {(3 * seos_pkg::ANGLE_W + seos_pkg::COUNT_W){1'b0}}});
        out_kind_d = seos_pkg::KIND_SUMMARY;
        out_last_d = 1'b1;
        phase_d    = 1'b0;
        pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load)          out_valid_q <= 1'b1;
      else if (tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign tvalid_o = out_valid_q;
  assign tdata_o  = out_data_q;
  assign tuser_o  = out_kind_q;
  assign tlast_o  = out_last_q;

  `SEOS_ASSERT(a_phase_has_entry, phase_q |-> !empty_i, "summary pending without an entry")
  `SEOS_ASSERT(a_phase_two_results, phase_q |-> (cmd_i.has_obj && cmd_i.has_sum),
               "summary pending on an entry that has one result")
  `SEOS_ASSERT_NEVER(a_summary_not_final,
                     out_valid_q && (out_kind_q == seos_pkg::KIND_SUMMARY) && !out_last_q,
                     "summary result not marked final")

endmodule

FILE: rtl/scan_edge_object_segmenter_unit.sv
// ----------------------------------------------------------------------------
// Scan edge object segmenter
// Finds objects in a range sweep by thresholded edges of the IR reading and
// reports object records and a per-sweep summary.
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      tdata angle, ir_value; tuser
//                                          first_point; tlast last_point
//  m_axis   out  m_axis_tvalid/tready      tdata result fields; tuser kind;
//                                          tlast final_result
//  cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A point is accepted every cycle while the entry queue has room; the front
// updates the sweep state in the cycle of the transfer.
// Results leave one per cycle from the output register while m_axis_tready is high,
// so a point that closes an object on the last point gives an object record and then the summary.
// The first result of a point is registered in the entry queue and then in the output register.
// Reset initialises all sweep state, empties the queue, clears the output valid flag and
// loads the register defaults.
// ----------------------------------------------------------------------------
module scan_edge_object_segmenter_unit #(
  parameter int unsigned IR_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [seos_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [seos_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // angle, ir_value
  input  logic [((8 + IR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // first_point
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // object_id, first angle, final angle, middle angle, max_abs_delta,
  // min_reading, max_reading, found_count
  output logic [((32 + 3 * IR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // kind
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned OUT_W   = ((32 + 3 * IR_BITS + 7) / 8) * 8;
  localparam int unsigned OBJ_W   = $bits(seos_pkg::obj_t);
  localparam int unsigned CMD_W   = $bits(seos_pkg::cmd_t);
  localparam int unsigned ENTRY_W = CMD_W + OBJ_W + 3 * IR_BITS;

  logic                 accept, push, full, empty, pop;
  seos_pkg::cmd_t       f_cmd, b_cmd;
  seos_pkg::obj_t       f_obj, b_obj;
  logic [IR_BITS-1:0]   f_delta, f_lo, f_hi, b_delta, b_lo, b_hi;
  logic [ENTRY_W-1:0]   q_in, q_out;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  seos_front #(
    .IR_BITS (IR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (accept),
    .angle_i    (s_axis_tdata[seos_pkg::ANGLE_W-1:0]),
    .ir_i       (s_axis_tdata[seos_pkg::ANGLE_W +: IR_BITS]),
    .first_i    (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .push_o     (push),
    .cmd_o      (f_cmd),
    .obj_o      (f_obj),
    .delta_o    (f_delta),
    .lo_o       (f_lo),
    .hi_o       (f_hi)
  );

  assign q_in = {f_cmd, f_obj, f_delta, f_lo, f_hi};

  seos_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (seos_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {b_cmd, b_obj, b_delta, b_lo, b_hi} = q_out;

  seos_back #(
    .IR_BITS (IR_BITS),
    .OUT_W   (OUT_W)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (b_cmd),
    .obj_i    (b_obj),
    .delta_i  (b_delta),
    .lo_i     (b_lo),
    .hi_i     (b_hi),
    .pop_o    (pop),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

endmodule

FILE: tb/sv/segment_result_checker.sv
// ----------------------------------------------------------------------------
// Result checker for the scan edge object segmenter
// Watches the point, result and register channels, tracks the sweep state of
// the segmenter on every accepted point and compares each result transfer,
// field by field, with the oldest predicted object record or sweep summary.
// ----------------------------------------------------------------------------
module segment_result_checker #(
  parameter int unsigned IR_BITS = 12
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [seos_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [seos_pkg::CFG_DATA_W-1:0]               cfg_data_i,
  input  logic                                          s_axis_tvalid,
  input  logic                                          s_axis_tready,
  input  logic [((8 + IR_BITS + 7) / 8) * 8 - 1:0]      s_axis_tdata,
  input  logic                                          s_axis_tuser,
  input  logic                                          s_axis_tlast,
  input  logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  input  logic [((32 + 3 * IR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                                          m_axis_tuser,
  input  logic                                          m_axis_tlast,
  output int                                            errors_o,
  output int                                            pending_o,
  output int                                            records_o,
  output int                                            summaries_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DELTA_LSB = 28;

  typedef struct packed {
    seos_pkg::kind_e                kind;
    logic [seos_pkg::COUNT_W-1:0]   id;
    logic [seos_pkg::ANGLE_W-1:0]   start_ang;
    logic [seos_pkg::ANGLE_W-1:0]   end_ang;
    logic [seos_pkg::ANGLE_W-1:0]   center;
    logic [IR_BITS-1:0]             peak_diff;
    logic [IR_BITS-1:0]             low_ir;
    logic [IR_BITS-1:0]             high_ir;
    logic [seos_pkg::COUNT_W-1:0]   count;
    logic                           final_res;
  } seg_result_t;

  // Register copies.
  logic [seos_pkg::THR_W-1:0]   edge_thr;
  logic [seos_pkg::MINW_W-1:0]  min_wid;
  logic [seos_pkg::MAXO_W-1:0]  max_obj;

  // Sweep state as the segmenter should hold it.
  logic [IR_BITS-1:0]           last_ir;
  logic                         obj_open;
  logic [seos_pkg::ANGLE_W-1:0] open_angle;
  logic [seos_pkg::ANGLE_W-1:0] last_angle;
  logic [seos_pkg::COUNT_W-1:0] reported;
  logic [IR_BITS-1:0]           peak_delta;
  logic [IR_BITS-1:0]           low_seen;
  logic [IR_BITS-1:0]           high_seen;

  seg_result_t awaited_results[$];
  int          mismatches;
  int          record_cnt;
  int          summary_cnt;

  assign errors_o    = mismatches;
  assign records_o   = record_cnt;
  assign summaries_o = summary_cnt;

  task automatic track_point(input logic [seos_pkg::ANGLE_W-1:0] ang,
                             input logic [IR_BITS-1:0] ir,
                             input logic first, input logic last);
    int          delta;
    int          mag;
    int          width;
    logic        closed_report;
    seg_result_t rec;
    seg_result_t summ;
    closed_report = 1'b0;
    rec = '0;
    summ = '0;
    if (first) begin
      obj_open   = 1'b0;
      open_angle = '0;
      reported   = '0;
      peak_delta = '0;
      low_seen   = ir;
      high_seen  = ir;
    end else begin
      delta = int'(ir) - int'(last_ir);
      mag = (delta < 0) ? -delta : delta;
      if (mag > int'(peak_delta)) peak_delta = mag[IR_BITS-1:0];
      if (ir < low_seen) low_seen = ir;
      if (ir > high_seen) high_seen = ir;
      if (!obj_open && delta > int'(edge_thr)) begin
        obj_open   = 1'b1;
        open_angle = last_angle;
      end else if (obj_open && (-delta > int'(edge_thr) || last)) begin
        width = int'(ang) - int'(open_angle);
        obj_open = 1'b0;
        // A backwards sweep gives a negative width and is never reported.
        if (width >= int'(min_wid) && reported < max_obj) begin
          reported = reported + 1'b1;
          rec.kind      = seos_pkg::KIND_OBJECT;
          rec.id        = reported;
          rec.start_ang = open_angle;
          rec.end_ang   = ang;
          rec.center    = seos_pkg::ANGLE_W'(({1'b0, open_angle} + {1'b0, ang}) >> 1);
          rec.count     = reported;
          closed_report = 1'b1;
        end
      end
    end
    if (closed_report) begin
      rec.final_res = !last;
      awaited_results.push_back(rec);
    end
    if (last) begin
      summ.kind      = seos_pkg::KIND_SUMMARY;
      summ.peak_diff = peak_delta;
      summ.low_ir    = low_seen;
      summ.high_ir   = high_seen;
      summ.count     = reported;
      summ.final_res = 1'b1;
      awaited_results.push_back(summ);
    end
    last_ir    = ir;
    last_angle = ang;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    seg_result_t want;
    if (awaited_results.size() == 0) begin
      $error("kind: expected no result, got %0d", m_axis_tuser);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      check_field("kind", want.kind, m_axis_tuser);
      check_field("object_id", want.id, m_axis_tdata[3:0]);
      check_field("opening angle", want.start_ang, m_axis_tdata[11:4]);
      check_field("closing angle", want.end_ang, m_axis_tdata[19:12]);
      check_field("middle angle", want.center, m_axis_tdata[27:20]);
      check_field("max_abs_delta", want.peak_diff, m_axis_tdata[DELTA_LSB +: IR_BITS]);
      check_field("min_reading", want.low_ir, m_axis_tdata[DELTA_LSB + IR_BITS +: IR_BITS]);
      check_field("max_reading", want.high_ir,
                  m_axis_tdata[DELTA_LSB + 2 * IR_BITS +: IR_BITS]);
      check_field("found_count", want.count,
                  m_axis_tdata[DELTA_LSB + 3 * IR_BITS +: seos_pkg::COUNT_W]);
      check_field("final_result", want.final_res, m_axis_tlast);
      if (m_axis_tuser == seos_pkg::KIND_SUMMARY) summary_cnt++;
      else record_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_thr   = seos_pkg::THR_RESET;
      min_wid    = seos_pkg::MINW_RESET;
      max_obj    = seos_pkg::MAXO_RESET;
      last_ir    = '0;
      obj_open   = 1'b0;
      open_angle = '0;
      last_angle = '0;
      reported   = '0;
      peak_delta = '0;
      low_seen   = '1;
      high_seen  = '0;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          seos_pkg::CFG_EDGE_THRESHOLD: edge_thr = cfg_data_i[seos_pkg::THR_W-1:0];
          seos_pkg::CFG_MIN_WIDTH:      min_wid  = cfg_data_i[seos_pkg::MINW_W-1:0];
          seos_pkg::CFG_MAX_OBJECTS:    max_obj  = cfg_data_i[seos_pkg::MAXO_W-1:0];
          default: ;
        endcase
      end
      // The first result of a point is registered in the entry queue and then in the output register, so
      // checking before predicting never pairs a result with its own point.
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        track_point(s_axis_tdata[7:0], s_axis_tdata[8 +: IR_BITS], s_axis_tuser, s_axis_tlast);
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the scan edge object segmenter
// Drives hand-picked points and then random sweeps and noise points through several register
// settings and handshake idle profiles; a checker beside the unit predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IR_W       = 12;
  localparam int unsigned S_W        = ((8 + IR_W + 7) / 8) * 8;
  localparam int unsigned M_W        = ((32 + 3 * IR_W + 7) / 8) * 8;
  localparam int          SETTLE     = 8;
  localparam int          QUIET_MAX  = 4000;
  localparam int          PER_PHASE  = 180;
  localparam int          NUM_PHASES = 6;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [seos_pkg::CFG_IDX_W-1:0]  cfg_idx = seos_pkg::CFG_EDGE_THRESHOLD;
  logic [seos_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic             s_valid = 1'b0;
  logic             s_ready;
  logic [S_W-1:0]   s_data = '0;
  logic             s_user = 1'b0;
  logic             s_last = 1'b0;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [M_W-1:0]   m_data;
  logic             m_user;
  logic             m_last;

  int errors;
  int pending;
  int records;
  int summaries;
  int points_sent = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 69;
  int quiet_cycles = 0;

  // Register settings per phase: threshold, minimum width, report limit.
  int thr_set[NUM_PHASES]  = '{0, 4095, 200, 60, 1000, 130};
  int minw_set[NUM_PHASES] = '{0, 180, 2, 10, 0, 4};
  int maxo_set[NUM_PHASES] = '{15, 0, 3, 1, 15, 10};

  always #1 clk_i = ~clk_i;

  scan_edge_object_segmenter_unit #(.IR_BITS(IR_W)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  segment_result_checker #(.IR_BITS(IR_W)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .errors_o      (errors),
    .pending_o     (pending),
    .records_o     (records),
    .summaries_o   (summaries)
  );

  always @(posedge clk_i) m_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  task automatic send_point(input int ang, input int ir, input bit first, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(S_W - 8 - IR_W){1'b0}}, IR_W'(ir), 8'(ang)};
    s_user  <= first;
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    points_sent++;
  endtask

  // Holds the point channel idle until every predicted result has arrived
  // and points that cause no result have left the pipeline.
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int ph);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= seos_pkg::CFG_EDGE_THRESHOLD;
    cfg_data <= seos_pkg::CFG_DATA_W'(thr_set[ph]);
    @(posedge clk_i);
    cfg_idx  <= seos_pkg::CFG_MIN_WIDTH;
    cfg_data <= seos_pkg::CFG_DATA_W'(minw_set[ph]);
    @(posedge clk_i);
    cfg_idx  <= seos_pkg::CFG_MAX_OBJECTS;
    cfg_data <= seos_pkg::CFG_DATA_W'(maxo_set[ph]);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_point(10, 500, 0, 0);    // rise right after reset, opens at angle 0
    send_point(20, 100, 0, 0);    // fall closes and reports
    send_point(0, 4095, 1, 1);    // one-point sweep
    send_point(0, 0, 1, 0);
    send_point(5, 4095, 0, 0);
    send_point(180, 0, 0, 0);     // widest object
    send_point(90, 3000, 0, 0);   // opens at 180
    send_point(30, 100, 0, 0);    // angle went backwards, closed silently
    send_point(40, 2000, 0, 0);
    send_point(50, 2100, 0, 1);   // last point closes: record and summary
    send_point(60, 4000, 0, 1);   // rise at the last point stays open
    send_point(70, 0, 0, 0);      // continues after the last point
    send_point(72, 130, 0, 0);    // delta equal to the threshold is no edge
    send_point(74, 261, 0, 0);
    send_point(75, 0, 0, 0);      // too narrow
    send_point(76, 200, 0, 0);
    send_point(80, 69, 0, 0);
    send_point(90, 4000, 0, 0);
    send_point(100, 4000, 1, 0);  // first marker drops the open object
    send_point(110, 0, 0, 1);
  endtask

  task automatic send_noise();
    send_point($urandom_range(180), $urandom_range(4095),
               $urandom_range(3) == 0, $urandom_range(3) == 0);
  endtask

  task automatic send_sweep();
    int  len;
    int  ang;
    int  base;
    int  lift;
    int  ir;
    bit  up;
    bit  keep_first;
    bit  keep_last;
    len = ($urandom_range(9) == 0) ? 0 : $urandom_range(2, 24);
    ang = $urandom_range(30);
    base = $urandom_range(1500);
    lift = 0;
    up = 1'b0;
    keep_first = ($urandom_range(19) != 0);
    keep_last = ($urandom_range(19) != 0);
    for (int k = 0; k <= len; k++) begin
      if (k > 0) begin
        if ($urandom_range(19) == 0) ang = (ang >= 20) ? ang - $urandom_range(1, 20) : 0;
        else ang = (ang + 12 > 180) ? 180 : ang + $urandom_range(1, 12);
        if ($urandom_range(3) == 0) begin
          up = !up;
          lift = $urandom_range(2600);
        end
      end
      ir = base + (up ? lift : 0) + $urandom_range(40);
      if (ir > 4095) ir = 4095;
      if ($urandom_range(49) == 0) ir = $urandom_range(1) ? 4095 : 0;
      send_point(ang, ir, (k == 0) && keep_first, (k == len) && keep_last);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_settings(ph);
      while (points_sent < 20 + (ph + 1) * PER_PHASE) begin
        if ($urandom_range(99) < 12) send_noise();
        else send_sweep();
        if (ph == 2 && $urandom_range(29) == 0) drain();
      end
    end
    drain();
    $display("Sent %0d points through %0d register settings and three idle profiles.",
             points_sent, NUM_PHASES);
    $display("Checked %0d object records and %0d sweep summaries.", records, summaries);
    if (errors == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: scan_edge_object_segmenter_unit.f
+incdir+rtl
rtl/seos_pkg.sv
rtl/seos_front.sv
rtl/seos_queue.sv
rtl/seos_back.sv
rtl/scan_edge_object_segmenter_unit.sv
tb/sv/segment_result_checker.sv
tb/sv/testbench.sv
